// ===== hw/rtl/rflt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rflt_pkg: shared types and constants of the recent flow table
// Request and result payloads, controller commands and datapath status.
// ----------------------------------------------------------------------------
package rflt_pkg;

  localparam int unsigned FLOW_W = 32;
  localparam int unsigned MAXE_W = 7;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned OCC_W  = 7;

  // request mode codes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [FLOW_W-1:0] flow_id;
  } rflt_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
  } rflt_rsp_t;

  typedef struct packed {
    logic load_req;
    logic match;
    logic shift_append;
    logic append;
    logic drop_oldest;
    logic emit;
  } rflt_cmd_t;

  typedef struct packed {
    logic hit;
    logic ins_en;
    logic full;
    logic over_cap;
    logic out_free;
  } rflt_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/recent_flow_lru_table.sv =====
`default_nettype none
// A request accepted in idle is registered, then the controller steps through match,
//   update, trim and result hand-off before the result shows in out_valid; a stalled
//   result register holds the controller in hand-off until the register frees.
// The table takes one request at a time; a finished result may wait in the output
//   register while the next request is taken.
// Reset (rst_n low, synchronous) empties the table and clears max_entries to zero.
// ----------------------------------------------------------------------------
// recent_flow_lru_table: ordered table of recently seen flows, oldest first
// Lookup reports presence and position; insert, unless max_entries is zero, moves the
// flow to the newest end and evicts the oldest when full or over max_entries.
// ----------------------------------------------------------------------------
module recent_flow_lru_table
  import rflt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  rflt_req_t         in_req,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output rflt_rsp_t         out_rsp,
  // capacity register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MAXE_W-1:0] cfg_data
);

  logic [MAXE_W-1:0] max_entries_r;
  rflt_cmd_t         cmd;
  rflt_sts_t         sts;

  // The user must change capacity only while idle; not enforced, writes taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_entries_r <= cfg_data;
    end
  end

  // Controller: hold the input stalled from accept until the result is loaded.
  rflt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: entry row with one comparator per entry, shift network and
  // the result register that parts the two channels.
  rflt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .max_entries (max_entries_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_rsp     (out_rsp)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/rflt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rflt_ctrl: sequencer of the recent flow table
// Steps one request through match, update, trim and result hand-off.
// ----------------------------------------------------------------------------
module rflt_ctrl
  import rflt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rflt_sts_t sts,
  output rflt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE,
    S_TRIM,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   in_stall_r;

  assign in_stall = in_stall_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:   cmd.load_req = in_valid;
      S_MATCH:  cmd.match = 1'b1;
      S_UPDATE: begin
        if (sts.ins_en) begin
          cmd.shift_append = sts.hit || sts.full;
          cmd.append       = !(sts.hit || sts.full);
        end
      end
      S_TRIM:   cmd.drop_oldest = sts.ins_en && sts.over_cap;
      S_FINISH: cmd.emit = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_MATCH;
            in_stall_r <= 1'b1;
          end
        end
        S_MATCH:  state_r <= S_UPDATE;
        S_UPDATE: state_r <= S_TRIM;
        S_TRIM:   state_r <= S_FINISH;
        S_FINISH: begin
          if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rflt_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rflt_dp: entry row, parallel compare and result register
// Entries are kept oldest first; shifts move each entry from its neighbor.
// ----------------------------------------------------------------------------
module rflt_dp
  import rflt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rflt_req_t         in_req,
  input  logic [MAXE_W-1:0] max_entries,
  input  rflt_cmd_t         cmd,
  output rflt_sts_t         sts,
  output logic              out_valid,
  input  logic              out_stall,
  output rflt_rsp_t         out_rsp
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW = (CW > MAXE_W) ? CW : MAXE_W;

  logic [FLOW_W-1:0] ent_r   [TABLE_DEPTH];
  logic [FLOW_W-1:0] ent_nxt [TABLE_DEPTH];
  logic [FLOW_W-1:0] up_w    [TABLE_DEPTH];

  logic [CW-1:0] count_r, count_nxt;
  rflt_req_t     req_r;
  logic          hit_r, hit_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic          out_valid_r;
  rflt_rsp_t     out_rsp_r;

  logic [IW-1:0] shift_idx;
  logic [CW-1:0] last_idx;
  logic [KW-1:0] cap_w;

  // neighbor toward the newest end
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_up
    if (g < TABLE_DEPTH - 1) begin : g_mid
      assign up_w[g] = ent_r[g+1];
    end else begin : g_end
      assign up_w[g] = '0;
    end
  end

  // entries are unique, so at most one match: OR the indexes together
  always_comb begin
    hit_nxt = 1'b0;
    pos_nxt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if ((CW'(i) < count_r) && (ent_r[i] == req_r.flow_id)) begin
        hit_nxt = 1'b1;
        pos_nxt = pos_nxt | IW'(i);
      end
    end
  end

  assign shift_idx = hit_r ? pos_r : '0;
  assign last_idx  = count_r - CW'(1);
  assign cap_w     = (KW'(max_entries) > KW'(TABLE_DEPTH)) ? KW'(TABLE_DEPTH)
                                                          : KW'(max_entries);

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    priority if (cmd.shift_append) begin
      // drop the entry at shift_idx and append the flow at the newest end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (IW'(i) >= shift_idx) begin
          if (CW'(i + 1) < count_r) begin
            ent_nxt[i] = up_w[i];
          end else if (CW'(i) == last_idx) begin
            ent_nxt[i] = req_r.flow_id;
          end
        end
      end
    end else if (cmd.append) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (CW'(i) == count_r) begin
          ent_nxt[i] = req_r.flow_id;
        end
      end
      count_nxt = count_r + CW'(1);
    end else if (cmd.drop_oldest) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        ent_nxt[i] = up_w[i];
      end
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (cmd.load_req) begin
      req_r <= in_req;
    end
    if (cmd.match) begin
      hit_r <= hit_nxt;
      pos_r <= pos_nxt;
    end
    if (cmd.emit) begin
      out_rsp_r.found     <= hit_r;
      out_rsp_r.position  <= POS_W'(pos_r);
      out_rsp_r.occupancy <= OCC_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.hit      = hit_r;
  assign sts.ins_en   = (req_r.mode == MODE_INSERT) && (max_entries != '0);
  assign sts.full     = (count_r == CW'(TABLE_DEPTH));
  assign sts.over_cap = (KW'(count_r) > cap_w);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rflt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rflt_checker: port-level checks of the recent flow table
// Bound to the top level; watches only its ports.
// ----------------------------------------------------------------------------
module rflt_checker
  import rflt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input rflt_rsp_t out_rsp
);

  // a miss reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.found) |-> (out_rsp.position == '0))
    else $error("miss result with nonzero position");

  // one request at a time: stall right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_rsp)))
    else $error("stalled result changed or dropped");

  // the request payload is sampled only at accept, but a new result needs one
  a_result_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in work");

endmodule

bind recent_flow_lru_table rflt_checker u_rflt_checker (.*);
`default_nettype wire
